// ----- hw/rtl/esv_pkg.sv -----
package esv_pkg;

    // Series storage
    localparam int MAX_SAMPLES = 256;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SAMPLE_W    = 16;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int SQ_W        = 2 * SAMPLE_W;

    // Distances used by any bin never exceed 127
    localparam int D_W         = 7;
    localparam int MAX_DIST    = (MAX_SAMPLES - 1 < 127) ? MAX_SAMPLES - 1 : 127;
    localparam int DIST_DEPTH  = 1 << D_W;
    localparam int DIST_W      = SQ_W + ADDR_W;

    // Bin accumulation and division
    localparam int SUM_W       = 47;
    localparam int PCNT_W      = 15;
    localparam int FRAC_W      = 8;
    localparam int NUM_W       = SUM_W + FRAC_W;
    localparam int DEN_W       = PCNT_W + 1;
    localparam int OUT_W       = 40;
    localparam int LAG_W       = 6;

    // Configuration
    localparam int CFG_W       = 7;
    localparam logic [CFG_W-1:0] MAX_LAG_RST   = 7'd16;
    localparam logic [CFG_W-1:0] BIN_WIDTH_RST = 7'd1;
    localparam logic [CFG_W-1:0] MAX_LAG_SAT   = 7'd64;

    typedef enum logic [0:0] {
        CFG_MAX_LAG   = 1'b0,
        CFG_BIN_WIDTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAIR_SETUP,
        S_PAIR_RUN,
        S_PAIR_DRAIN,
        S_BIN_SETUP,
        S_BIN_RUN,
        S_BIN_DRAIN,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic close;
        logic pair_init;
        logic pair_issue;
        logic bin_setup;
        logic bin_issue;
        logic div_start;
        logic emit;
        logic bin_next;
    } t_cmd;

    typedef struct packed {
        logic no_bins;
        logic has_pairs;
        logic pair_last;
        logic pair_idle;
        logic bin_last;
        logic bin_idle;
        logic sum_zero;
        logic div_busy;
        logic bin_final;
    } t_stat;

endpackage

// ----- hw/rtl/esv_div.sv -----
module esv_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [esv_pkg::NUM_W-1:0]     i_num,
    input  logic [esv_pkg::DEN_W-1:0]     i_den,
    output logic [esv_pkg::OUT_W-1:0]     o_quo,
    output logic                          o_busy
);
    import esv_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_nq;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    w_shift;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    // One quotient bit per cycle, restoring form
    assign w_shift = {r_rem, r_nq[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(NUM_W);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_nq  <= {r_nq[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        end
    end

    assign o_quo  = r_nq[OUT_W-1:0];
    assign o_busy = r_busy;

endmodule

// ----- hw/rtl/esv_dp.sv -----
module esv_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  esv_pkg::t_cmd                     i_cmd,
    output esv_pkg::t_stat                    o_stat,
    input  logic signed [esv_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_cfg_we,
    input  esv_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [esv_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                              o_result_valid,
    output logic [esv_pkg::LAG_W-1:0]         o_lag_centre,
    output logic [esv_pkg::OUT_W-1:0]         o_semivariance,
    output logic                              o_bin_valid,
    output logic                              o_final_bin
);
    import esv_pkg::*;

    // Configuration
    logic [CFG_W-1:0] r_max_lag;
    logic [CFG_W-1:0] r_bin_width;

    // Series
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_n;
    logic [D_W-1:0]   r_dmax;
    logic [CNT_W-1:0] w_n_after;
    logic [CNT_W-1:0] w_n_m1;
    logic             w_full;

    logic signed [SAMPLE_W-1:0] sample_mem [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0] r_rd_a;
    logic signed [SAMPLE_W-1:0] r_rd_b;

    // Pair loop
    logic [D_W-1:0]    r_d;
    logic [ADDR_W-1:0] r_j;
    logic [ADDR_W-1:0] w_addr_b;
    logic              w_end_d;

    logic               r_s1_vld, r_s2_vld, r_s3_vld;
    logic               r_s1_end, r_s2_end, r_s3_end;
    logic [D_W-1:0]     r_s1_d, r_s2_d, r_s3_d;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [2*DIFF_W-1:0] w_prod;
    logic [SQ_W-1:0]    r_sq;
    logic [DIST_W-1:0]  r_acc;
    logic [DIST_W-1:0]  w_acc_sum;

    logic [DIST_W-1:0]  dist_mem [DIST_DEPTH];
    logic [DIST_W-1:0]  r_dist_rd;

    // Bin loop
    logic [LAG_W-1:0]  r_i;
    logic [CFG_W-1:0]  w_w;
    logic [CFG_W-1:0]  w_lim;
    logic [CFG_W:0]    w_ipw;
    logic [D_W-1:0]    w_lo;
    logic [D_W-1:0]    w_hi;
    logic              w_final;

    logic [D_W-1:0]    r_bd;
    logic [D_W-1:0]    r_bhi;
    logic              r_bempty;
    logic              r_b1_vld;
    logic [D_W-1:0]    r_b1_d;
    logic [SUM_W-1:0]  r_sum;
    logic [PCNT_W-1:0] r_cnt;

    logic [OUT_W-1:0]  w_quo;
    logic              w_div_busy;

    logic              r_out_vld;
    logic [LAG_W-1:0]  r_out_lag;
    logic [OUT_W-1:0]  r_out_sv;
    logic              r_out_bv;
    logic              r_out_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lag   <= MAX_LAG_RST;
            r_bin_width <= BIN_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_LAG:   r_max_lag   <= i_cfg_data;
                CFG_BIN_WIDTH: r_bin_width <= i_cfg_data;
            endcase
        end
    end

    // Sample loading; drop samples once the store is full
    assign w_full    = (r_count == CNT_W'(MAX_SAMPLES));
    assign w_n_after = w_full ? r_count : r_count + 1'b1;
    assign w_n_m1    = w_n_after - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= i_cmd.close ? '0 : w_n_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.close) begin
            r_n    <= w_n_after;
            r_dmax <= (w_n_m1 > CNT_W'(MAX_DIST)) ? D_W'(MAX_DIST) : w_n_m1[D_W-1:0];
        end
    end

    assign w_addr_b = r_j + ADDR_W'(r_d);
    assign w_end_d  = ((CNT_W'(w_addr_b) + 1'b1) == r_n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            sample_mem[r_count[ADDR_W-1:0]] <= i_sample;
        end
        r_rd_a <= sample_mem[r_j];
        r_rd_b <= sample_mem[w_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_init) begin
            r_d <= D_W'(1);
            r_j <= '0;
        end else if (i_cmd.pair_issue) begin
            if (w_end_d) begin
                r_j <= '0;
                r_d <= r_d + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.pair_issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    assign w_prod    = r_diff * r_diff;
    assign w_acc_sum = r_acc + DIST_W'(r_sq);

    always_ff @(posedge i_clk) begin
        r_s1_end <= w_end_d;
        r_s1_d   <= r_d;
        r_s2_end <= r_s1_end;
        r_s2_d   <= r_s1_d;
        r_diff   <= DIFF_W'(r_rd_b) - DIFF_W'(r_rd_a);
        r_s3_end <= r_s2_end;
        r_s3_d   <= r_s2_d;
        r_sq     <= w_prod[SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_init) begin
            r_acc <= '0;
        end else if (r_s3_vld) begin
            r_acc <= r_s3_end ? '0 : w_acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_vld && r_s3_end) begin
            dist_mem[r_s3_d] <= w_acc_sum;
        end
        r_dist_rd <= dist_mem[r_bd];
    end

    // Bin bounds
    assign w_w     = (r_bin_width == '0) ? CFG_W'(1) : r_bin_width;
    assign w_lim   = (r_max_lag > MAX_LAG_SAT) ? MAX_LAG_SAT : r_max_lag;
    assign w_ipw   = (CFG_W + 1)'(r_i) + (CFG_W + 1)'(w_w);
    assign w_final = (w_ipw >= (CFG_W + 1)'(w_lim));
    assign w_lo    = (D_W'(r_i) > w_w) ? (D_W'(r_i) - w_w) : D_W'(1);
    assign w_hi    = (w_ipw > (CFG_W + 1)'(r_dmax)) ? r_dmax : w_ipw[D_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_init) begin
            r_i <= '0;
        end else if (i_cmd.bin_next) begin
            r_i <= w_ipw[LAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
        end else begin
            r_b1_vld <= i_cmd.bin_issue && !r_bempty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_d <= r_bd;
        if (i_cmd.bin_setup) begin
            r_bd     <= w_lo;
            r_bhi    <= w_hi;
            r_bempty <= (w_lo > w_hi);
        end else if (i_cmd.bin_issue && !r_bempty) begin
            r_bd <= r_bd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_setup) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (r_b1_vld) begin
            r_sum <= r_sum + SUM_W'(r_dist_rd);
            r_cnt <= r_cnt + PCNT_W'(r_n - CNT_W'(r_b1_d));
        end
    end

    esv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({r_sum, FRAC_W'(0)}),
        .i_den   ({r_cnt, 1'b0}),
        .o_quo   (w_quo),
        .o_busy  (w_div_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_lag <= r_i;
            r_out_sv  <= (r_sum == '0) ? '0 : w_quo;
            r_out_bv  <= (r_sum != '0);
            r_out_fin <= w_final;
        end
    end

    assign o_stat.no_bins   = (w_lim == '0);
    assign o_stat.has_pairs = (r_n >= CNT_W'(2));
    assign o_stat.pair_last = w_end_d && (r_d == r_dmax);
    assign o_stat.pair_idle = !(r_s1_vld || r_s2_vld || r_s3_vld);
    assign o_stat.bin_last  = r_bempty || (r_bd == r_bhi);
    assign o_stat.bin_idle  = !r_b1_vld;
    assign o_stat.sum_zero  = (r_sum == '0);
    assign o_stat.div_busy  = w_div_busy;
    assign o_stat.bin_final = w_final;

    assign o_result_valid = r_out_vld;
    assign o_lag_centre   = r_out_lag;
    assign o_semivariance = r_out_sv;
    assign o_bin_valid    = r_out_bv;
    assign o_final_bin    = r_out_fin;

endmodule

// ----- hw/rtl/esv_ctrl.sv -----
module esv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last,
    input  esv_pkg::t_stat i_stat,
    output esv_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import esv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load  = i_start;
                o_cmd.close = i_start && i_last;
                if (i_start && i_last) begin
                    n_state = S_PAIR_SETUP;
                end
            end
            S_PAIR_SETUP: begin
                o_cmd.pair_init = 1'b1;
                priority if (i_stat.no_bins) begin
                    n_state = S_IDLE;
                end else if (!i_stat.has_pairs) begin
                    n_state = S_BIN_SETUP;
                end else begin
                    n_state = S_PAIR_RUN;
                end
            end
            S_PAIR_RUN: begin
                o_cmd.pair_issue = 1'b1;
                if (i_stat.pair_last) begin
                    n_state = S_PAIR_DRAIN;
                end
            end
            S_PAIR_DRAIN: begin
                if (i_stat.pair_idle) begin
                    n_state = S_BIN_SETUP;
                end
            end
            S_BIN_SETUP: begin
                o_cmd.bin_setup = 1'b1;
                n_state = S_BIN_RUN;
            end
            S_BIN_RUN: begin
                o_cmd.bin_issue = 1'b1;
                if (i_stat.bin_last) begin
                    n_state = S_BIN_DRAIN;
                end
            end
            S_BIN_DRAIN: begin
                if (i_stat.bin_idle) begin
                    n_state = S_DIV_START;
                end
            end
            S_DIV_START: begin
                if (i_stat.sum_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.bin_final) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.bin_next = 1'b1;
                    n_state = S_BIN_SETUP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- hw/rtl/empirical_semivariogram_core.sv -----
// Load: one sample item per cycle while busy is low; the item flagged last starts the run.
// Pair pass, n samples: a setup state, then (n-d) pairs for each d = 1..min(n-1,127), then
// a drain (setup only when n < 2). Each bin: setup, the distances in the bin, a drain, emit,
// and the one-bit-a-cycle divide when its sum is nonzero; max_lag 0 gives no bins.
// Throughput: one pair per cycle through the square/accumulate pipeline; each result is
// strobed one cycle, no stall. Sync active-low reset clears count, control and config.
module empirical_semivariogram_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [esv_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    input  logic                                i_cfg_we,
    input  esv_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [esv_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                o_result_valid,
    output logic [esv_pkg::LAG_W-1:0]           o_lag_centre,
    output logic [esv_pkg::OUT_W-1:0]           o_semivariance,
    output logic                                o_bin_valid,
    output logic                                o_final_bin
);
    import esv_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequence the load, pair-sum, bin-sum, divide and emit phases
    esv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_last),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Hold the series, the per-distance sums, the bin accumulators and the divider
    esv_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_sample       (i_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_lag_centre   (o_lag_centre),
        .o_semivariance (o_semivariance),
        .o_bin_valid    (o_bin_valid),
        .o_final_bin    (o_final_bin)
    );

    // Results never come in adjacent cycles
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // The last bin of a run leaves the block ready for the next series
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_final_bin) |-> !busy)
        else $error("still busy after the final bin");

    // Divide only a nonzero sum and never while a divide is running
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> (!w_stat.sum_zero && !w_stat.div_busy))
        else $error("divider started on zero sum or while busy");

    // A bin without a valid sum reports zero
    a_zero_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_bin_valid) |-> (o_semivariance == '0))
        else $error("invalid bin carries a nonzero value");

endmodule
